// ----- rtl/core/edu_pkg.sv -----
// ----------------------------------------------------------------------------
// edu_pkg
// Shared widths, constants, codes and helpers of the Euler cell update block.
// ----------------------------------------------------------------------------
package edu_pkg;

  localparam int MAX_CELLS = 4096;
  localparam int CNT_W     = $clog2(MAX_CELLS);
  localparam int IDX_W     = 12;
  localparam int DATA_W    = 32;
  localparam int COEF_W    = 31;
  localparam int MUL_W     = 33;
  localparam int PROD_W    = 2 * MUL_W;
  localparam int ACC_W     = 44;
  localparam int DIVD_W    = 63;
  localparam int DIVS_W    = 33;
  localparam int DCNT_W    = $clog2(DIVD_W);
  localparam int ADDR_W    = 5;

  localparam logic [2:0] REG_GAMMA_M1 = 3'd0;
  localparam logic [2:0] REG_DT_DX    = 3'd1;
  localparam logic [2:0] REG_COEFF2   = 3'd2;
  localparam logic [2:0] REG_COEFF4   = 3'd3;
  localparam logic [2:0] REG_LEFT_E   = 3'd4;
  localparam logic [2:0] REG_RIGHT_E  = 3'd5;

  localparam logic [COEF_W-1:0] GAMMA_M1_RST = 31'd6710886;
  localparam logic [COEF_W-1:0] LEFT_E_RST   = 31'd46661632;
  localparam logic [COEF_W-1:0] RIGHT_E_RST  = 31'd4194304;

  localparam logic signed [DATA_W-1:0] LEFT_MASS  = 32'sd16777216;
  localparam logic signed [DATA_W-1:0] LEFT_MOM   = 32'sd12582912;
  localparam logic signed [DATA_W-1:0] RIGHT_MASS = 32'sd2097152;
  localparam logic signed [DATA_W-1:0] MASS_FLOOR = 32'sd17;
  localparam logic [33:0]              KE_CAP     = 34'h2_0000_0000;

  typedef enum logic [2:0] {
    OP_FT,
    OP_V2,
    OP_V4,
    OP_SQ,
    OP_PRESS
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EMIT,
    S_MUL,
    S_MWAIT,
    S_DIV,
    S_OUT,
    S_PRESS,
    S_SHIFT
  } state_t;

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [47:0] v);
    if (v > 48'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -48'sd2147483648) begin
      return 32'sh80000000;
    end else begin
      return v[DATA_W-1:0];
    end
  endfunction

  function automatic logic [DATA_W-1:0] mag32(input logic signed [DATA_W-1:0] v);
    return v[DATA_W-1] ? (~v + 32'd1) : v;
  endfunction

endpackage

// ----- rtl/core/edu_mul.sv -----
// ----------------------------------------------------------------------------
// edu_mul
// Shared signed multiplier with registered operands and registered product.
// ----------------------------------------------------------------------------
module edu_mul (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic signed [edu_pkg::MUL_W-1:0]    a,
  input  logic signed [edu_pkg::MUL_W-1:0]    b,
  output logic                                done,
  output logic signed [edu_pkg::PROD_W-1:0]   p
);

  logic signed [edu_pkg::MUL_W-1:0] a_q;
  logic signed [edu_pkg::MUL_W-1:0] b_q;
  logic                             v1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= start;
      done <= v1;
    end
    if (start) begin
      a_q <= a;
      b_q <= b;
    end
    p <= a_q * b_q;
  end

endmodule

// ----- rtl/core/edu_div.sv -----
// ----------------------------------------------------------------------------
// edu_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module edu_div (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [edu_pkg::DIVD_W-1:0]        dividend,
  input  logic [edu_pkg::DIVS_W-1:0]        divisor,
  output logic                              done,
  output logic [edu_pkg::DIVD_W-1:0]        quotient
);

  logic                              busy;
  logic [edu_pkg::DCNT_W-1:0]        cnt;
  logic [edu_pkg::DIVS_W-1:0]        rem;
  logic [edu_pkg::DIVS_W-1:0]        dvs;
  logic [edu_pkg::DIVS_W:0]          rem_sh;
  logic                              fits;

  assign rem_sh = {rem, quotient[edu_pkg::DIVD_W-1]};
  assign fits   = rem_sh >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
      dvs      <= divisor;
      cnt      <= edu_pkg::DCNT_W'(edu_pkg::DIVD_W - 1);
    end else if (busy) begin
      rem      <= fits ? edu_pkg::DIVS_W'(rem_sh - {1'b0, dvs})
                       : rem_sh[edu_pkg::DIVS_W-1:0];
      quotient <= {quotient[edu_pkg::DIVD_W-2:0], fits};
      cnt      <= cnt - 1'b1;
    end
  end

endmodule

// ----- rtl/core/euler_1d_dissipation_update_unit.sv -----
// ----------------------------------------------------------------------------
// euler_1d_dissipation_update_unit
// Streaming 1-D Euler cell update with second and fourth difference damping;
// at a shock only a doubled second difference is applied. Each item runs the
// shared multiplier and, unless its mass is zero, the divider of the kinetic
// energy term; boundary results take no products, and an output stall holds
// the item. One item is in work at a time. Synchronous reset restores
// register defaults and clears all windows and the cell counter.
// ----------------------------------------------------------------------------
module euler_1d_dissipation_update_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [edu_pkg::ADDR_W-1:0]        paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [31:0]                mass,
  input  logic signed [31:0]                momentum,
  input  logic signed [31:0]                energy,
  input  logic signed [31:0]                flux_mass,
  input  logic signed [31:0]                flux_momentum,
  input  logic signed [31:0]                flux_energy,
  input  logic                              last_cell,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [edu_pkg::IDX_W-1:0]         cell_index,
  output logic signed [31:0]                new_mass,
  output logic signed [31:0]                new_momentum,
  output logic signed [31:0]                new_energy,
  output logic                              shock_detected,
  output logic                              grid_done
);

  logic [edu_pkg::COEF_W-1:0] gamma_m1, dt_dx, coeff2, coeff4, left_e, right_e;

  logic signed [31:0] cw [4][3];
  logic signed [31:0] pw [3];
  logic signed [31:0] fw [3][3];
  logic signed [31:0] cur_q [3];
  logic signed [31:0] fl_q [3];
  logic signed [31:0] res [3];
  logic [edu_pkg::CNT_W-1:0] cnt;
  logic               last_q;
  logic [1:0]         off;
  logic [1:0]         vsel;
  logic               shock_q;
  logic               int_q;
  logic signed [edu_pkg::ACC_W-1:0] acc;
  logic signed [34:0] ke_q;
  logic signed [31:0] pnew;

  edu_pkg::state_t state, state_next;
  edu_pkg::op_t    op;

  logic mul_start, mul_done, div_start, div_done, out_load;
  logic signed [edu_pkg::MUL_W-1:0]  mul_a, mul_b;
  logic signed [edu_pkg::PROD_W-1:0] mul_p;
  logic [edu_pkg::DIVD_W-1:0]        div_q;

  edu_mul u_mul (
    .clk(clk), .rst(rst), .start(mul_start), .a(mul_a), .b(mul_b),
    .done(mul_done), .p(mul_p)
  );

  edu_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(mul_p[edu_pkg::DIVD_W-1:0]),
    .divisor({edu_pkg::mag32(cur_q[0]), 1'b0}), .done(div_done), .quotient(div_q)
  );

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      gamma_m1 <= edu_pkg::GAMMA_M1_RST;
      dt_dx    <= '0;
      coeff2   <= '0;
      coeff4   <= '0;
      left_e   <= edu_pkg::LEFT_E_RST;
      right_e  <= edu_pkg::RIGHT_E_RST;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[4:2])
        edu_pkg::REG_GAMMA_M1: gamma_m1 <= pwdata[30:0];
        edu_pkg::REG_DT_DX:    dt_dx    <= pwdata[30:0];
        edu_pkg::REG_COEFF2:   coeff2   <= pwdata[30:0];
        edu_pkg::REG_COEFF4:   coeff4   <= pwdata[30:0];
        edu_pkg::REG_LEFT_E:   left_e   <= pwdata[30:0];
        edu_pkg::REG_RIGHT_E:  right_e  <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      edu_pkg::REG_GAMMA_M1: prdata = {1'b0, gamma_m1};
      edu_pkg::REG_DT_DX:    prdata = {1'b0, dt_dx};
      edu_pkg::REG_COEFF2:   prdata = {1'b0, coeff2};
      edu_pkg::REG_COEFF4:   prdata = {1'b0, coeff4};
      edu_pkg::REG_LEFT_E:   prdata = {1'b0, left_e};
      edu_pkg::REG_RIGHT_E:  prdata = {1'b0, right_e};
      default:               prdata = '0;
    endcase
  end

  // Pressure sensor on the stored window: 20*|d2p| > sum of magnitudes.
  logic signed [34:0] d2p;
  logic [34:0]        d2p_mag;
  logic [39:0]        sens_lhs;
  logic [33:0]        sens_sum;
  logic               shock_now;

  assign d2p      = 35'(pw[0]) - (35'(pw[1]) <<< 1) + 35'(pw[2]);
  assign d2p_mag  = d2p[34] ? (~d2p + 35'd1) : d2p;
  assign sens_lhs = (40'(d2p_mag) << 4) + (40'(d2p_mag) << 2);
  assign sens_sum = 34'(edu_pkg::mag32(pw[0])) + 34'(edu_pkg::mag32(pw[1]))
                  + 34'(edu_pkg::mag32(pw[2]));
  assign shock_now = sens_lhs > 40'(sens_sum);

  logic [edu_pkg::CNT_W-1:0] idx;
  logic right_b, left_b;

  assign idx     = cnt + edu_pkg::CNT_W'(off) - edu_pkg::CNT_W'(2);
  assign right_b = last_q && (off != 2'd0);
  assign left_b  = !right_b && (idx <= edu_pkg::CNT_W'(1));

  logic signed [47:0] fd_w, d2_w, d4_w;
  logic signed [31:0] fd, d2, d4, internal;
  logic [31:0]        mu_mag;

  assign fd_w = 48'(fw[1][vsel]) - 48'(fw[2][vsel]);
  assign d2_w = 48'(cw[0][vsel]) - (48'(cw[1][vsel]) <<< 1) + 48'(cw[2][vsel]);
  assign d4_w = 48'(cur_q[vsel]) - (48'(cw[0][vsel]) <<< 2)
              + (48'(cw[1][vsel]) <<< 2) + (48'(cw[1][vsel]) <<< 1)
              - (48'(cw[2][vsel]) <<< 2) + 48'(cw[3][vsel]);
  assign fd       = edu_pkg::sat32(fd_w);
  assign d2       = edu_pkg::sat32(d2_w);
  assign d4       = edu_pkg::sat32(d4_w);
  assign internal = edu_pkg::sat32(48'(cur_q[2]) - 48'(ke_q));
  assign mu_mag   = edu_pkg::mag32(cur_q[1]);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (op)
      edu_pkg::OP_FT: begin
        mul_a = $signed({2'b00, dt_dx});
        mul_b = 33'(fd);
      end
      edu_pkg::OP_V2: begin
        mul_a = $signed({2'b00, coeff2});
        mul_b = 33'(d2);
      end
      edu_pkg::OP_V4: begin
        mul_a = $signed({2'b00, coeff4});
        mul_b = 33'(d4);
      end
      edu_pkg::OP_SQ: begin
        mul_a = $signed({1'b0, mu_mag});
        mul_b = $signed({1'b0, mu_mag});
      end
      edu_pkg::OP_PRESS: begin
        mul_a = $signed({2'b00, gamma_m1});
        mul_b = 33'(internal);
      end
    endcase
  end

  logic signed [41:0] sh24;
  logic signed [42:0] sh23;
  logic signed [edu_pkg::ACC_W-1:0] acc_ft, acc_add;
  logic signed [31:0] acc_sat;
  logic [33:0]        q_cap;
  logic               mass_zero;

  assign sh24      = $signed(mul_p[65:24]);
  assign sh23      = $signed(mul_p[65:23]);
  assign acc_ft    = edu_pkg::ACC_W'(cw[1][vsel]) - edu_pkg::ACC_W'(sh24);
  assign acc_add   = acc + ((op == edu_pkg::OP_V2 && shock_q) ? edu_pkg::ACC_W'(sh23)
                                                              : edu_pkg::ACC_W'(sh24));
  assign acc_sat   = edu_pkg::sat32(48'(acc_add));
  assign q_cap     = (div_q > edu_pkg::DIVD_W'(edu_pkg::KE_CAP)) ? edu_pkg::KE_CAP
                                                                 : div_q[33:0];
  assign mass_zero = (cur_q[0] == '0);

  assign in_ready  = (state == edu_pkg::S_IDLE);
  assign mul_start = (state == edu_pkg::S_MUL);
  assign div_start = (state == edu_pkg::S_MWAIT) && mul_done && (op == edu_pkg::OP_SQ)
                   && !mass_zero;
  assign out_load  = (state == edu_pkg::S_OUT) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= edu_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      edu_pkg::S_IDLE: begin
        if (in_valid) begin
          state_next = (last_cell || cnt >= edu_pkg::CNT_W'(2)) ? edu_pkg::S_EMIT
                                                                : edu_pkg::S_PRESS;
        end
      end
      edu_pkg::S_EMIT: begin
        state_next = (right_b || left_b) ? edu_pkg::S_OUT : edu_pkg::S_MUL;
      end
      edu_pkg::S_MUL: begin
        state_next = edu_pkg::S_MWAIT;
      end
      edu_pkg::S_MWAIT: begin
        if (mul_done) begin
          unique case (op)
            edu_pkg::OP_FT: state_next = edu_pkg::S_MUL;
            edu_pkg::OP_V2: begin
              state_next = (shock_q && vsel == 2'd2) ? edu_pkg::S_OUT : edu_pkg::S_MUL;
            end
            edu_pkg::OP_V4: begin
              state_next = (vsel == 2'd2) ? edu_pkg::S_OUT : edu_pkg::S_MUL;
            end
            edu_pkg::OP_SQ:    state_next = mass_zero ? edu_pkg::S_MUL : edu_pkg::S_DIV;
            edu_pkg::OP_PRESS: state_next = edu_pkg::S_SHIFT;
          endcase
        end
      end
      edu_pkg::S_DIV: begin
        if (div_done) begin
          state_next = edu_pkg::S_MUL;
        end
      end
      edu_pkg::S_OUT: begin
        if (out_load) begin
          state_next = (last_q && off != 2'd2) ? edu_pkg::S_EMIT : edu_pkg::S_PRESS;
        end
      end
      edu_pkg::S_PRESS: begin
        state_next = edu_pkg::S_MUL;
      end
      edu_pkg::S_SHIFT: begin
        state_next = edu_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      cnt       <= '0;
      for (int d = 0; d < 4; d++) begin
        for (int v = 0; v < 3; v++) begin
          cw[d][v] <= '0;
        end
      end
      for (int d = 0; d < 3; d++) begin
        pw[d] <= '0;
        for (int v = 0; v < 3; v++) begin
          fw[d][v] <= '0;
        end
      end
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (state == edu_pkg::S_SHIFT) begin
        for (int d = 3; d > 0; d--) begin
          for (int v = 0; v < 3; v++) begin
            cw[d][v] <= cw[d-1][v];
          end
        end
        for (int d = 2; d > 0; d--) begin
          pw[d] <= pw[d-1];
          for (int v = 0; v < 3; v++) begin
            fw[d][v] <= fw[d-1][v];
          end
        end
        for (int v = 0; v < 3; v++) begin
          cw[0][v] <= cur_q[v];
          fw[0][v] <= fl_q[v];
        end
        pw[0] <= pnew;
        if (last_q) begin
          cnt <= '0;
        end else if (cnt < edu_pkg::CNT_W'(edu_pkg::MAX_CELLS - 1)) begin
          cnt <= cnt + 1'b1;
        end
      end
    end

    unique case (state)
      edu_pkg::S_IDLE: begin
        if (in_valid) begin
          cur_q[0] <= mass;
          cur_q[1] <= momentum;
          cur_q[2] <= energy;
          fl_q[0]  <= flux_mass;
          fl_q[1]  <= flux_momentum;
          fl_q[2]  <= flux_energy;
          last_q   <= last_cell;
          shock_q  <= shock_now;
          if (!last_cell || cnt >= edu_pkg::CNT_W'(2)) begin
            off <= 2'd0;
          end else if (cnt == edu_pkg::CNT_W'(1)) begin
            off <= 2'd1;
          end else begin
            off <= 2'd2;
          end
        end
      end
      edu_pkg::S_EMIT: begin
        vsel  <= 2'd0;
        op    <= edu_pkg::OP_FT;
        int_q <= !(right_b || left_b);
        if (right_b) begin
          res[0] <= edu_pkg::RIGHT_MASS;
          res[1] <= '0;
          res[2] <= $signed({1'b0, right_e});
        end else if (left_b) begin
          res[0] <= edu_pkg::LEFT_MASS;
          res[1] <= edu_pkg::LEFT_MOM;
          res[2] <= $signed({1'b0, left_e});
        end
      end
      edu_pkg::S_MWAIT: begin
        if (mul_done) begin
          unique case (op)
            edu_pkg::OP_FT: begin
              acc <= acc_ft;
              op  <= edu_pkg::OP_V2;
            end
            edu_pkg::OP_V2: begin
              acc <= acc_add;
              if (shock_q) begin
                res[vsel] <= acc_sat;
                vsel      <= vsel + 2'd1;
                op        <= edu_pkg::OP_FT;
              end else begin
                op <= edu_pkg::OP_V4;
              end
            end
            edu_pkg::OP_V4: begin
              res[vsel] <= acc_sat;
              vsel      <= vsel + 2'd1;
              op        <= edu_pkg::OP_FT;
            end
            edu_pkg::OP_SQ: begin
              if (mass_zero) begin
                ke_q <= '0;
              end
              op <= edu_pkg::OP_PRESS;
            end
            edu_pkg::OP_PRESS: begin
              pnew <= edu_pkg::sat32(48'(sh24));
            end
          endcase
        end
      end
      edu_pkg::S_DIV: begin
        if (div_done) begin
          ke_q <= cur_q[0][31] ? -$signed({1'b0, q_cap}) : $signed({1'b0, q_cap});
        end
      end
      edu_pkg::S_OUT: begin
        if (out_load) begin
          cell_index     <= edu_pkg::IDX_W'(idx);
          new_mass       <= (res[0] < edu_pkg::MASS_FLOOR) ? edu_pkg::MASS_FLOOR : res[0];
          new_momentum   <= res[1];
          new_energy     <= res[2];
          shock_detected <= int_q && shock_q;
          grid_done      <= last_q && (off == 2'd2);
          off            <= off + 2'd1;
        end
      end
      edu_pkg::S_PRESS: begin
        op <= edu_pkg::OP_SQ;
      end
      edu_pkg::S_MUL, edu_pkg::S_SHIFT: ;
    endcase
  end

endmodule
